>>> hdl/sctr_pkg.sv
`timescale 1ns / 1ps

package sctr_pkg;

  // Field and datapath widths.
  localparam int POS_W     = 32;
  localparam int DIR_W     = 18;
  localparam int LEN_W     = 28;
  localparam int SUM_W     = LEN_W + 1;
  localparam int DIFF_W    = POS_W + 1;
  localparam int NUM_W     = DIFF_W + 1;
  localparam int DIR_FRAC  = 16;
  localparam int DVD_W     = DIFF_W + DIR_FRAC;
  localparam int QUO_W     = DVD_W + 1;
  localparam int P_W       = DIFF_W + DIR_W + 1;
  localparam int S_W       = P_W - DIR_FRAC;
  localparam int R2_W      = 2 * SUM_W;
  localparam int SQ_W      = 2 * S_W;
  localparam int RES_W     = 36;
  localparam int TS_W      = RES_W + 1;
  localparam int MX_W      = DIR_W + POS_W;
  localparam int EX_W      = MX_W - DIR_FRAC + 1;
  localparam int EXN_W     = SUM_W + 1;
  localparam int CSQ_W     = 2 * EXN_W + 1;
  localparam int ONE_Q12   = 4096;

  // Pipeline shape.
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int SQ_STEPS  = RES_W;
  localparam int SIDE_DLY  = DIV_LAT - SQ_STEPS + 1;
  localparam int PIPE_D    = DIV_LAT + 7;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [DIR_W-1:0]  dir_t;
  typedef logic        [DIR_W-1:0]  dmag_t;
  typedef logic        [LEN_W-1:0]  len_t;
  typedef logic        [SUM_W-1:0]  sum_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic        [DIFF_W-1:0] dmag33_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic        [DVD_W-1:0]  dvd_t;
  typedef logic signed [QUO_W-1:0]  quo_t;
  typedef logic signed [P_W-1:0]    prod_p_t;
  typedef logic signed [S_W-1:0]    s_t;
  typedef logic        [R2_W-1:0]   r2_t;
  typedef logic signed [SQ_W-1:0]   wide_t;
  typedef logic        [SQ_W-1:0]   sq_rem_t;
  typedef logic        [RES_W-1:0]  res_t;
  typedef logic signed [TS_W-1:0]   tside_t;
  typedef logic signed [MX_W-1:0]   mx_t;
  typedef logic signed [EX_W-1:0]   ex_t;
  typedef logic        [EX_W-1:0]   exmag_t;
  typedef logic signed [EXN_W-1:0]  exn_t;
  typedef logic signed [CSQ_W-1:0]  csq_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5,
    CFG_NEAR     = 3'd6,
    CFG_FAR      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    pos_t target_x;
    pos_t target_y;
    pos_t target_z;
    len_t target_half_height;
    len_t target_radius;
    len_t mover_half_height;
    len_t mover_radius;
  } in_t;

  typedef struct packed {
    logic hit;
    logic hit_on_cap;
    pos_t hit_distance;
  } out_t;

  typedef struct packed {
    diff_t lx;
    diff_t ly;
    sum_t  r;
    r2_t   r2;
    logic  par_miss;
  } div_side_t;

  typedef struct packed {
    s_t   s;
    logic outside;
    logic skip;
  } sq_side_t;

  typedef struct packed {
    tside_t t;
    logic   ok;
  } side_res_t;

  typedef struct packed {
    logic [DIR_W-1:0] rem;
    dvd_t             work;
  } div_state_t;

  typedef struct packed {
    sq_rem_t rem;
    res_t    res;
  } sq_state_t;

  // One restoring division step: shift in the next dividend bit, emit one quotient bit.
  function automatic div_state_t div_step(div_state_t s, dmag_t dd);
    logic [DIR_W:0] trial;
    div_state_t     r;
    trial = {s.rem, s.work[DVD_W-1]};
    r.work = {s.work[DVD_W-2:0], 1'b0};
    if (trial >= {1'b0, dd}) begin
      trial = trial - {1'b0, dd};
      r.work[0] = 1'b1;
    end
    r.rem = trial[DIR_W-1:0];
    return r;
  endfunction

  // One square root step for result bit b, working on the remainder v - res^2.
  function automatic sq_state_t sq_step(sq_state_t s, int unsigned b);
    sq_rem_t   trial;
    sq_state_t r;
    trial = (sq_rem_t'(s.res) << (b + 1)) | (sq_rem_t'(1) << (2 * b));
    r = s;
    if (trial <= s.rem) begin
      r.rem = s.rem - trial;
      r.res = s.res | (res_t'(1) << b);
    end
    return r;
  endfunction

endpackage

>>> hdl/sctr_div.sv
`timescale 1ns / 1ps

// Two pipelined restoring dividers sharing one divisor, one quotient bit per stage.
module sctr_div (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  sctr_pkg::num_t        num_a_i,
  input  sctr_pkg::num_t        num_b_i,
  input  sctr_pkg::dir_t        den_i,
  input  sctr_pkg::div_side_t   side_i,
  output sctr_pkg::quo_t        quo_a_o,
  output sctr_pkg::quo_t        quo_b_o,
  output sctr_pkg::div_side_t   side_o
);

  sctr_pkg::div_state_t st_a_q [sctr_pkg::DIV_STEPS];
  sctr_pkg::div_state_t st_b_q [sctr_pkg::DIV_STEPS];
  logic [1:0]           neg_q  [sctr_pkg::DIV_STEPS];
  sctr_pkg::div_side_t  side_q [sctr_pkg::DIV_STEPS];

  sctr_pkg::dmag_t      dd;
  sctr_pkg::dmag33_t    mag_a, mag_b;
  sctr_pkg::div_state_t init_a, init_b;
  logic [1:0]           neg_in;

  always_comb begin
    dd = den_i[sctr_pkg::DIR_W-1] ? sctr_pkg::dmag_t'(-den_i) : sctr_pkg::dmag_t'(den_i);
    mag_a = num_a_i[sctr_pkg::NUM_W-1] ? sctr_pkg::dmag33_t'(-num_a_i)
                                       : sctr_pkg::dmag33_t'(num_a_i);
    mag_b = num_b_i[sctr_pkg::NUM_W-1] ? sctr_pkg::dmag33_t'(-num_b_i)
                                       : sctr_pkg::dmag33_t'(num_b_i);
    init_a.rem  = '0;
    init_a.work = sctr_pkg::dvd_t'(mag_a) << sctr_pkg::DIR_FRAC;
    init_b.rem  = '0;
    init_b.work = sctr_pkg::dvd_t'(mag_b) << sctr_pkg::DIR_FRAC;
    neg_in = {num_b_i[sctr_pkg::NUM_W-1] ^ den_i[sctr_pkg::DIR_W-1],
              num_a_i[sctr_pkg::NUM_W-1] ^ den_i[sctr_pkg::DIR_W-1]};
  end

  for (genvar k = 0; k < sctr_pkg::DIV_STEPS; k++) begin : g_step
    sctr_pkg::div_state_t src_a, src_b;
    logic [1:0]           src_neg;
    sctr_pkg::div_side_t  src_side;
    if (k == 0) begin : g_first
      assign src_a    = init_a;
      assign src_b    = init_b;
      assign src_neg  = neg_in;
      assign src_side = side_i;
    end else begin : g_next
      assign src_a    = st_a_q[k-1];
      assign src_b    = st_b_q[k-1];
      assign src_neg  = neg_q[k-1];
      assign src_side = side_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_a_q[k] <= sctr_pkg::div_step(src_a, dd);
        st_b_q[k] <= sctr_pkg::div_step(src_b, dd);
        neg_q[k]  <= src_neg;
        side_q[k] <= src_side;
      end
    end
  end

  sctr_pkg::quo_t      quo_a_q, quo_b_q;
  sctr_pkg::div_side_t side_out_q;
  sctr_pkg::quo_t      ua, ub;

  assign ua = sctr_pkg::quo_t'(st_a_q[sctr_pkg::DIV_STEPS-1].work);
  assign ub = sctr_pkg::quo_t'(st_b_q[sctr_pkg::DIV_STEPS-1].work);

  // Apply the quotient sign so that the result truncates toward zero.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_a_q    <= neg_q[sctr_pkg::DIV_STEPS-1][0] ? -ua : ua;
      quo_b_q    <= neg_q[sctr_pkg::DIV_STEPS-1][1] ? -ub : ub;
      side_out_q <= side_q[sctr_pkg::DIV_STEPS-1];
    end
  end

  assign quo_a_o = quo_a_q;
  assign quo_b_o = quo_b_q;
  assign side_o  = side_out_q;

endmodule

>>> hdl/sctr_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage, most significant first.
module sctr_sqrt (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  sctr_pkg::sq_rem_t    val_i,
  input  sctr_pkg::sq_side_t   side_i,
  output sctr_pkg::res_t       root_o,
  output sctr_pkg::sq_side_t   side_o
);

  sctr_pkg::sq_state_t st_q   [sctr_pkg::SQ_STEPS];
  sctr_pkg::sq_side_t  side_q [sctr_pkg::SQ_STEPS];
  sctr_pkg::sq_state_t init;

  assign init.rem = val_i;
  assign init.res = '0;

  for (genvar k = 0; k < sctr_pkg::SQ_STEPS; k++) begin : g_step
    sctr_pkg::sq_state_t src;
    sctr_pkg::sq_side_t  src_side;
    if (k == 0) begin : g_first
      assign src      = init;
      assign src_side = side_i;
    end else begin : g_next
      assign src      = st_q[k-1];
      assign src_side = side_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k]   <= sctr_pkg::sq_step(src, sctr_pkg::SQ_STEPS - 1 - k);
        side_q[k] <= src_side;
      end
    end
  end

  assign root_o = st_q[sctr_pkg::SQ_STEPS-1].res;
  assign side_o = side_q[sctr_pkg::SQ_STEPS-1];

endmodule

>>> hdl/swept_cylinder_cylinder_trace.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output register is not held by a stall;
// the 49-step slab divider and 36-step square root are fully pipelined and the whole
// pipeline advances on one enable.
// Reset: asynchronous, active low; clears all valid bits and loads the ray registers
// with their defaults. Datapath registers are not reset.

module swept_cylinder_cylinder_trace (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sctr_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sctr_pkg::out_t    out_data_o
);

  // ---------------------------------------------------------------------------
  // Ray registers: the user must not change them while a request is in flight
  // (not enforced); every stage reads them directly instead of piped copies.
  // ---------------------------------------------------------------------------
  sctr_pkg::pos_t org_x_q, org_y_q, org_z_q, near_q, far_q;
  sctr_pkg::dir_t dir_x_q, dir_y_q, dir_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      dir_x_q <= sctr_pkg::dir_t'(65536);
      dir_y_q <= '0;
      dir_z_q <= '0;
      near_q  <= '0;
      far_q   <= sctr_pkg::pos_t'(32'h7FFF_FFFF);
    end else if (cfg_we_i) begin
      unique case (sctr_pkg::cfg_reg_e'(cfg_idx_i))
        sctr_pkg::CFG_ORIGIN_X: org_x_q <= cfg_wdata_i;
        sctr_pkg::CFG_ORIGIN_Y: org_y_q <= cfg_wdata_i;
        sctr_pkg::CFG_ORIGIN_Z: org_z_q <= cfg_wdata_i;
        sctr_pkg::CFG_DIR_X:    dir_x_q <= cfg_wdata_i[sctr_pkg::DIR_W-1:0];
        sctr_pkg::CFG_DIR_Y:    dir_y_q <= cfg_wdata_i[sctr_pkg::DIR_W-1:0];
        sctr_pkg::CFG_DIR_Z:    dir_z_q <= cfg_wdata_i[sctr_pkg::DIR_W-1:0];
        sctr_pkg::CFG_NEAR:     near_q  <= cfg_wdata_i;
        sctr_pkg::CFG_FAR:      far_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The pipeline moves as a whole whenever the output register
  // is empty or being taken, so a stall freezes every stage in place.
  // ---------------------------------------------------------------------------
  logic                         en;
  logic [sctr_pkg::PIPE_D-1:0]  vld_q;

  assign en          = !vld_q[sctr_pkg::PIPE_D-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[sctr_pkg::PIPE_D-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[sctr_pkg::PIPE_D-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: combined sizes and offsets from the ray origin to the target.
  // ---------------------------------------------------------------------------
  sctr_pkg::sum_t  s1_h_q, s1_r_q;
  sctr_pkg::diff_t s1_lx_q, s1_ly_q, s1_dzc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_h_q   <= sctr_pkg::sum_t'(in_data_i.target_half_height)
                + sctr_pkg::sum_t'(in_data_i.mover_half_height);
      s1_r_q   <= sctr_pkg::sum_t'(in_data_i.target_radius)
                + sctr_pkg::sum_t'(in_data_i.mover_radius);
      s1_lx_q  <= sctr_pkg::diff_t'(in_data_i.target_x) - sctr_pkg::diff_t'(org_x_q);
      s1_ly_q  <= sctr_pkg::diff_t'(in_data_i.target_y) - sctr_pkg::diff_t'(org_y_q);
      s1_dzc_q <= sctr_pkg::diff_t'(in_data_i.target_z) - sctr_pkg::diff_t'(org_z_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: slab plane numerators, the parallel-ray slab check, and the first
  // products of the side test (projection onto the direction and squares).
  // ---------------------------------------------------------------------------
  sctr_pkg::num_t    s2_num_a_q, s2_num_b_q;
  sctr_pkg::prod_p_t s2_p_q;
  sctr_pkg::wide_t   s2_lxx_q, s2_lyy_q;
  sctr_pkg::div_side_t s2_side_q;
  sctr_pkg::dmag33_t abs_dzc;
  sctr_pkg::div_side_t s2_side_d;

  always_comb begin
    abs_dzc = s1_dzc_q[sctr_pkg::DIFF_W-1] ? sctr_pkg::dmag33_t'(-s1_dzc_q)
                                           : sctr_pkg::dmag33_t'(s1_dzc_q);
    s2_side_d.lx       = s1_lx_q;
    s2_side_d.ly       = s1_ly_q;
    s2_side_d.r        = s1_r_q;
    s2_side_d.r2       = sctr_pkg::r2_t'(s1_r_q) * sctr_pkg::r2_t'(s1_r_q);
    s2_side_d.par_miss = abs_dzc >= sctr_pkg::dmag33_t'(s1_h_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_num_a_q <= sctr_pkg::num_t'(s1_dzc_q) - sctr_pkg::num_t'(s1_h_q);
      s2_num_b_q <= sctr_pkg::num_t'(s1_dzc_q) + sctr_pkg::num_t'(s1_h_q);
      s2_p_q     <= sctr_pkg::prod_p_t'(s1_lx_q) * sctr_pkg::prod_p_t'(dir_x_q)
                  + sctr_pkg::prod_p_t'(s1_ly_q) * sctr_pkg::prod_p_t'(dir_y_q);
      s2_lxx_q   <= sctr_pkg::wide_t'(s1_lx_q) * sctr_pkg::wide_t'(s1_lx_q);
      s2_lyy_q   <= sctr_pkg::wide_t'(s1_ly_q) * sctr_pkg::wide_t'(s1_ly_q);
      s2_side_q  <= s2_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Side test, stages 3 to 5: projected distance s, squared distance to the
  // axis, and the radicand r^2 - m^2 handed to the square root.
  // ---------------------------------------------------------------------------
  sctr_pkg::s_t    s3_s_q, s4_s_q;
  sctr_pkg::wide_t s3_l2_q, s4_l2_q, s4_ss_q;
  sctr_pkg::r2_t   s3_r2_q, s4_r2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_s_q  <= sctr_pkg::s_t'(s2_p_q >>> sctr_pkg::DIR_FRAC);
      s3_l2_q <= s2_lxx_q + s2_lyy_q;
      s3_r2_q <= s2_side_q.r2;
      s4_s_q  <= s3_s_q;
      s4_l2_q <= s3_l2_q;
      s4_ss_q <= sctr_pkg::wide_t'(s3_s_q) * sctr_pkg::wide_t'(s3_s_q);
      s4_r2_q <= s3_r2_q;
    end
  end

  sctr_pkg::wide_t    r2w, m2;
  sctr_pkg::sq_side_t s5_side_d, s5_side_q;
  sctr_pkg::sq_rem_t  s5_v_d, s5_v_q;

  always_comb begin
    r2w = sctr_pkg::wide_t'(s4_r2_q);
    m2  = s4_l2_q - s4_ss_q;
    s5_side_d.s       = s4_s_q;
    s5_side_d.outside = s4_l2_q > r2w;
    // The ray points away from a circle it starts outside of, or passes it by.
    s5_side_d.skip    = (s4_s_q < 0 && s5_side_d.outside) || (m2 > r2w);
    s5_v_d = s5_side_d.skip ? '0 : sctr_pkg::sq_rem_t'(r2w - m2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q <= s5_side_d;
      s5_v_q    <= s5_v_d;
    end
  end

  sctr_pkg::res_t     sq_root;
  sctr_pkg::sq_side_t sq_side;

  sctr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (s5_v_q),
    .side_i (s5_side_q),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // Side hit distance: entry point from outside, exit point from inside. It is
  // then held in a delay line until the slab window catches up.
  sctr_pkg::side_res_t side_d;
  sctr_pkg::side_res_t dly_q [sctr_pkg::SIDE_DLY];

  always_comb begin
    side_d.t  = sq_side.outside ? sctr_pkg::tside_t'(sq_side.s) - sctr_pkg::tside_t'(sq_root)
                                : sctr_pkg::tside_t'(sq_side.s) + sctr_pkg::tside_t'(sq_root);
    side_d.ok = !sq_side.skip;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= side_d;
      for (int i = 1; i < sctr_pkg::SIDE_DLY; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Slab window: both z-plane distances divided by the z direction.
  // ---------------------------------------------------------------------------
  sctr_pkg::quo_t      quo_a, quo_b;
  sctr_pkg::div_side_t dv_side;

  sctr_div u_div (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_a_i (s2_num_a_q),
    .num_b_i (s2_num_b_q),
    .den_i   (dir_z_q),
    .side_i  (s2_side_q),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b),
    .side_o  (dv_side)
  );

  sctr_pkg::quo_t near_w, far_w;
  sctr_pkg::quo_t w_t0_d, w_t1_d;
  logic           w_miss_d, w_cap_en_d;

  assign near_w = sctr_pkg::quo_t'(near_q);
  assign far_w  = sctr_pkg::quo_t'(far_q);

  // A zero z direction makes the window [0, 1.0] when the ray lies inside the slab.
  // A cap hit at or past the far limit is reported as a miss, and no side hit
  // can then qualify either, so the cap test is simply left disabled.
  always_comb begin
    if (dir_z_q != '0) begin
      w_t0_d   = (quo_a < quo_b) ? quo_a : quo_b;
      w_t1_d   = (quo_a < quo_b) ? quo_b : quo_a;
      w_miss_d = (w_t1_d < near_w) || (w_t0_d >= far_w);
    end else begin
      w_t0_d   = '0;
      w_t1_d   = sctr_pkg::quo_t'(sctr_pkg::ONE_Q12);
      w_miss_d = dv_side.par_miss;
    end
    w_cap_en_d = !w_miss_d && (w_t0_d >= near_w) && (w_t0_d < far_w);
  end

  // Window registers, then the cap test at t0 over three stages. Once the cap
  // test is enabled, t0 lies within the 32-bit distance range.
  sctr_pkg::quo_t      w_t0_q, w_t1_q, c1_t0_q, c1_t1_q, c2_t0_q, c2_t1_q;
  sctr_pkg::quo_t      c3_t0_q, c3_t1_q;
  logic                w_miss_q, w_cap_q, c1_miss_q, c1_cap_q, c2_miss_q, c2_cap_q;
  logic                c3_miss_q, c3_cap_q;
  sctr_pkg::div_side_t w_side_q, c1_side_q;
  sctr_pkg::r2_t       c2_r2_q, c3_r2_q;
  sctr_pkg::mx_t       c1_mx_q, c1_my_q;
  sctr_pkg::exn_t      c2_ex_q, c2_ey_q;
  sctr_pkg::csq_t      c3_sum_q;
  sctr_pkg::ex_t       ex, ey;
  sctr_pkg::exmag_t    abs_ex, abs_ey;
  logic                near_d;

  always_comb begin
    ex = sctr_pkg::ex_t'(c1_mx_q >>> sctr_pkg::DIR_FRAC) - sctr_pkg::ex_t'(c1_side_q.lx);
    ey = sctr_pkg::ex_t'(c1_my_q >>> sctr_pkg::DIR_FRAC) - sctr_pkg::ex_t'(c1_side_q.ly);
    abs_ex = ex[sctr_pkg::EX_W-1] ? sctr_pkg::exmag_t'(-ex) : sctr_pkg::exmag_t'(ex);
    abs_ey = ey[sctr_pkg::EX_W-1] ? sctr_pkg::exmag_t'(-ey) : sctr_pkg::exmag_t'(ey);
    near_d = (abs_ex < sctr_pkg::exmag_t'(c1_side_q.r))
          && (abs_ey < sctr_pkg::exmag_t'(c1_side_q.r));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_t0_q    <= w_t0_d;
      w_t1_q    <= w_t1_d;
      w_miss_q  <= w_miss_d;
      w_cap_q   <= w_cap_en_d;
      w_side_q  <= dv_side;

      c1_mx_q   <= sctr_pkg::mx_t'(dir_x_q) * sctr_pkg::mx_t'(sctr_pkg::pos_t'(w_t0_q));
      c1_my_q   <= sctr_pkg::mx_t'(dir_y_q) * sctr_pkg::mx_t'(sctr_pkg::pos_t'(w_t0_q));
      c1_t0_q   <= w_t0_q;
      c1_t1_q   <= w_t1_q;
      c1_miss_q <= w_miss_q;
      c1_cap_q  <= w_cap_q;
      c1_side_q <= w_side_q;

      c2_ex_q   <= sctr_pkg::exn_t'(ex);
      c2_ey_q   <= sctr_pkg::exn_t'(ey);
      c2_t0_q   <= c1_t0_q;
      c2_t1_q   <= c1_t1_q;
      c2_miss_q <= c1_miss_q;
      c2_cap_q  <= c1_cap_q && near_d;
      c2_r2_q   <= c1_side_q.r2;

      c3_sum_q  <= sctr_pkg::csq_t'(c2_ex_q) * sctr_pkg::csq_t'(c2_ex_q)
                 + sctr_pkg::csq_t'(c2_ey_q) * sctr_pkg::csq_t'(c2_ey_q);
      c3_t0_q   <= c2_t0_q;
      c3_t1_q   <= c2_t1_q;
      c3_miss_q <= c2_miss_q;
      c3_cap_q  <= c2_cap_q;
      c3_r2_q   <= c2_r2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Final stage: a cap hit wins; otherwise the side hit must fall inside the
  // window and before the far limit. Anything else reports the far limit.
  // ---------------------------------------------------------------------------
  sctr_pkg::side_res_t side_f;
  sctr_pkg::quo_t      t_w;
  logic                cap_hit, side_hit;
  sctr_pkg::out_t      out_d, out_q;

  always_comb begin
    side_f   = dly_q[sctr_pkg::SIDE_DLY-1];
    t_w      = sctr_pkg::quo_t'(side_f.t);
    cap_hit  = c3_cap_q && (c3_sum_q < sctr_pkg::csq_t'(c3_r2_q));
    side_hit = !c3_miss_q && side_f.ok && (t_w >= near_w) && (t_w >= c3_t0_q)
            && (t_w <= c3_t1_q) && (t_w < far_w);
    out_d.hit        = cap_hit || side_hit;
    out_d.hit_on_cap = cap_hit;
    if (cap_hit) begin
      out_d.hit_distance = sctr_pkg::pos_t'(c3_t0_q);
    end else if (side_hit) begin
      out_d.hit_distance = sctr_pkg::pos_t'(side_f.t);
    end else begin
      out_d.hit_distance = far_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> tb/swept_cylinder_cylinder_trace_tb.sv
`timescale 1ns / 1ps

module swept_cylinder_cylinder_trace_tb;

  // Directed stimulus row: a request plus, where it is obvious, its result.
  typedef struct {
    sctr_pkg::in_t  req;
    bit             fixed;
    sctr_pkg::out_t res;
  } dir_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [2:0]     cfg_idx_i;
  logic [31:0]    cfg_wdata_i;
  logic           in_valid_i;
  logic           in_stall_o;
  sctr_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  sctr_pkg::out_t out_data_o;

  // Shadow copy of the ray registers, kept in step with every write.
  sctr_pkg::pos_t ray_ox, ray_oy, ray_oz;
  sctr_pkg::dir_t ray_dx, ray_dy, ray_dz;
  sctr_pkg::pos_t win_near, win_far;

  sctr_pkg::out_t hit_q[$];
  int             n_errors;
  int             send_idle_pct;
  int             recv_idle_pct;
  bit             hold_go;
  int             hold_cnt;
  dir_row_t       rows[$];

  swept_cylinder_cylinder_trace dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Generous ceiling: the slowest legal run is well under a tenth of this.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Integer square root, floored, of a wide non-negative value.
  function automatic longint wide_sqrt(logic signed [127:0] v);
    longint             root;
    longint             cand;
    logic signed [127:0] cw;
    root = 0;
    if (v <= 0) return 0;
    for (int b = 35; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      cw = cand;
      if (cw * cw <= v) root = cand;
    end
    return root;
  endfunction

  // First contact distance of the swept mover against one target cylinder.
  function automatic sctr_pkg::out_t trace_hit(sctr_pkg::in_t it);
    longint ox, oy, oz, dx, dy, dz, tmin, tmax;
    longint cx, cy, cz, h, r, r2, t0, t1, hit_dist;
    longint a, b, ex, ey, lx, ly, s, q, t;
    logic signed [127:0] l2, r2w, m2, sw, lxw, lyw;
    bit miss, found, cap, outside;
    sctr_pkg::out_t o;
    ox = ray_ox; oy = ray_oy; oz = ray_oz;
    dx = ray_dx; dy = ray_dy; dz = ray_dz;
    tmin = win_near; tmax = win_far;
    cx = it.target_x; cy = it.target_y; cz = it.target_z;
    h = longint'(it.target_half_height) + longint'(it.mover_half_height);
    r = longint'(it.target_radius) + longint'(it.mover_radius);
    r2 = r * r;
    t0 = 0; t1 = sctr_pkg::ONE_Q12; hit_dist = tmax;
    miss = 0; found = 0; cap = 0;

    // Slab window from the two z planes; a level ray only tests the slab.
    if (dz != 0) begin
      a = ((cz - oz - h) * 65536) / dz;
      b = ((cz - oz + h) * 65536) / dz;
      t0 = (a < b) ? a : b;
      t1 = (a < b) ? b : a;
      if (t1 < tmin || t0 >= tmax) miss = 1;
    end else if (mag(cz - oz) >= h) begin
      miss = 1;
    end

    // Cap test at slab entry.
    if (!miss && t0 >= tmin) begin
      ex = ox + ((dx * t0) >>> 16) - cx;
      ey = oy + ((dy * t0) >>> 16) - cy;
      if (mag(ex) < r && mag(ey) < r) begin
        if (ex * ex + ey * ey < r2) begin
          found = 1; cap = 1; hit_dist = t0;
        end
      end
    end

    // Side test: 2-D ray against the combined circle.
    if (!miss && !found) begin
      lx = cx - ox;
      ly = cy - oy;
      s = (lx * dx + ly * dy) >>> 16;
      lxw = lx;
      lyw = ly;
      l2 = lxw * lxw + lyw * lyw;
      r2w = r2;
      outside = (l2 > r2w);
      if (!(s < 0 && outside)) begin
        sw = s;
        m2 = l2 - sw * sw;
        if (m2 <= r2w) begin
          q = wide_sqrt(r2w - m2);
          t = outside ? s - q : s + q;
          if (t >= tmin && t >= t0 && t <= t1) begin
            found = 1; hit_dist = t;
          end
        end
      end
    end

    if (!found || hit_dist >= tmax) begin
      found = 0; cap = 0; hit_dist = tmax;
    end
    o.hit = found;
    o.hit_on_cap = cap;
    o.hit_distance = sctr_pkg::pos_t'(hit_dist);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Result checker: every accepted result pairs with the oldest pending one.
  always @(posedge clk_i) begin
    sctr_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hit_q.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.hit_distance, 0);
      end else begin
        want = hit_q.pop_front();
        if (out_data_o.hit !== want.hit)
          report_mismatch("hit", out_data_o.hit, want.hit);
        if (out_data_o.hit_on_cap !== want.hit_on_cap)
          report_mismatch("hit_on_cap", out_data_o.hit_on_cap, want.hit_on_cap);
        if (out_data_o.hit_distance !== want.hit_distance)
          report_mismatch("hit_distance", out_data_o.hit_distance, want.hit_distance);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Fully random request, every field at its full width.
  function automatic sctr_pkg::in_t rand_raw();
    sctr_pkg::in_t it;
    it.target_x = $urandom;
    it.target_y = $urandom;
    it.target_z = $urandom;
    it.target_half_height = sctr_pkg::len_t'($urandom);
    it.target_radius = sctr_pkg::len_t'($urandom);
    it.mover_half_height = sctr_pkg::len_t'($urandom);
    it.mover_radius = sctr_pkg::len_t'($urandom);
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(sctr_pkg::in_t it, bit fixed, sctr_pkg::out_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i <= rand_raw();
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    hit_q.insert(hit_q.size(), fixed ? res : trace_hit(it));
    @(negedge clk_i);
  endtask

  // Wait until every request has come back, then let the pipeline empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (hit_q.size() != 0) @(negedge clk_i);
    repeat (sctr_pkg::PIPE_D + 8) @(negedge clk_i);
  endtask

  // Direction writes carry random bits above the register width. The enable
  // is left high; the caller drops it once the last write is done.
  task automatic cfg_write(sctr_pkg::cfg_reg_e idx, logic [31:0] val);
    logic [31:0] wd;
    wd = val;
    if (idx inside {sctr_pkg::CFG_DIR_X, sctr_pkg::CFG_DIR_Y, sctr_pkg::CFG_DIR_Z})
      wd = {14'($urandom_range(0, 16383)), val[17:0]};
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= wd;
    case (idx)
      sctr_pkg::CFG_ORIGIN_X: ray_ox = wd;
      sctr_pkg::CFG_ORIGIN_Y: ray_oy = wd;
      sctr_pkg::CFG_ORIGIN_Z: ray_oz = wd;
      sctr_pkg::CFG_DIR_X:    ray_dx = wd[17:0];
      sctr_pkg::CFG_DIR_Y:    ray_dy = wd[17:0];
      sctr_pkg::CFG_DIR_Z:    ray_dz = wd[17:0];
      sctr_pkg::CFG_NEAR:     win_near = wd;
      sctr_pkg::CFG_FAR:      win_far = wd;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic sctr_pkg::in_t mk(longint tx, longint ty, longint tz,
                                       longint th, longint tr, longint mh, longint mr);
    sctr_pkg::in_t it;
    it.target_x = sctr_pkg::pos_t'(tx);
    it.target_y = sctr_pkg::pos_t'(ty);
    it.target_z = sctr_pkg::pos_t'(tz);
    it.target_half_height = sctr_pkg::len_t'(th);
    it.target_radius = sctr_pkg::len_t'(tr);
    it.mover_half_height = sctr_pkg::len_t'(mh);
    it.mover_radius = sctr_pkg::len_t'(mr);
    return it;
  endfunction

  function automatic sctr_pkg::out_t res_of(bit hit, bit cap, longint hit_dist);
    sctr_pkg::out_t o;
    o.hit = hit;
    o.hit_on_cap = cap;
    o.hit_distance = sctr_pkg::pos_t'(hit_dist);
    return o;
  endfunction

  function automatic void add_row(sctr_pkg::in_t req, bit fixed, sctr_pkg::out_t res);
    dir_row_t row;
    row.req = req;
    row.fixed = fixed;
    row.res = res;
    rows.insert(rows.size(), row);
  endfunction

  function automatic sctr_pkg::dir_t rand_dir();
    case ($urandom_range(0, 5))
      0: return sctr_pkg::dir_t'(65536);
      1: return sctr_pkg::dir_t'(-65536);
      2: return sctr_pkg::dir_t'(0);
      3: return sctr_pkg::dir_t'($urandom_range(0, 2) - 1);
      default: return sctr_pkg::dir_t'(longint'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Most requests sit near the ray so the cap and side tests both see hits.
  function automatic sctr_pkg::in_t rand_req();
    longint t, px, py, pz;
    if ($urandom_range(0, 3) == 0) begin
      return rand_raw();
    end
    t = longint'($urandom_range(0, 40 * sctr_pkg::ONE_Q12)) - 4 * sctr_pkg::ONE_Q12;
    px = longint'(ray_ox) + ((longint'(ray_dx) * t) >>> 16);
    py = longint'(ray_oy) + ((longint'(ray_dy) * t) >>> 16);
    pz = longint'(ray_oz) + ((longint'(ray_dz) * t) >>> 16);
    px += longint'($urandom_range(0, 4 * sctr_pkg::ONE_Q12)) - 2 * sctr_pkg::ONE_Q12;
    py += longint'($urandom_range(0, 4 * sctr_pkg::ONE_Q12)) - 2 * sctr_pkg::ONE_Q12;
    pz += longint'($urandom_range(0, 4 * sctr_pkg::ONE_Q12)) - 2 * sctr_pkg::ONE_Q12;
    return mk(px, py, pz, $urandom_range(0, 2 * sctr_pkg::ONE_Q12),
              $urandom_range(0, 2 * sctr_pkg::ONE_Q12),
              $urandom_range(0, sctr_pkg::ONE_Q12), $urandom_range(0, sctr_pkg::ONE_Q12));
  endfunction

  initial begin
    sctr_pkg::in_t  it;
    sctr_pkg::out_t none;
    longint big;
    n_errors = 0;
    hold_go = 1'b0;
    hold_cnt = 0;
    send_idle_pct = 16;
    recv_idle_pct = 87;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = sctr_pkg::CFG_ORIGIN_X;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b1;
    ray_ox = 0; ray_oy = 0; ray_oz = 0;
    ray_dx = sctr_pkg::dir_t'(65536); ray_dy = 0; ray_dz = 0;
    win_near = 0; win_far = 32'h7fffffff;
    none = res_of(0, 0, 0);
    big = 28'hfffffff;

    // Directed rows under the reset registers: a level ray along +x, window [0, 1.0].
    add_row(mk(0, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 32'h7fffffff));
    add_row(mk(0, 0, 0, 4096, 4096, 0, 0), 1, res_of(1, 1, 0));
    add_row(mk(0, 0, 0, big, big, big, big), 1, res_of(1, 1, 0));
    add_row(mk(0, 0, 32'h7fffffff, 4096, 4096, 0, 0), 1, res_of(0, 0, 32'h7fffffff));
    add_row(mk(0, 0, -32'sd2147483648, 4096, 4096, 4096, 4096), 1,
            res_of(0, 0, 32'h7fffffff));
    // Target ahead but beyond the one-unit window, target behind, side hit inside.
    add_row(mk(40960, 0, 0, 4096, 4096, 0, 0), 0, none);
    add_row(mk(-40960, 0, 0, 4096, 4096, 0, 0), 0, none);
    add_row(mk(6000, 100, 0, 4096, 2048, 0, 1024), 0, none);
    add_row(mk(2048, 3000, 0, 4096, 2048, 0, 1024), 0, none);
    add_row(mk(0, 5000, 0, 4096, 4096, 0, 1000), 0, none);
    add_row(mk(-32'sd2147483648, -32'sd2147483648, 0, big, big, 0, 0), 0, none);
    add_row(mk(32'h7fffffff, 32'h7fffffff, 1, big, big, big, big), 0, none);
    add_row(mk(0, 0, 0, 0, 4096, 1, 0), 1, res_of(1, 1, 0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_req(rows[i].req, rows[i].fixed, rows[i].res);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 16 : (ph < 6) ? 87 : 0;
      recv_idle_pct = (ph < 3) ? 87 : (ph < 6) ? 16 : 0;
      case (ph)
        0: begin
          // Steepest directions and the widest accepted range.
          cfg_write(sctr_pkg::CFG_DIR_X, 32'(-65536));
          cfg_write(sctr_pkg::CFG_DIR_Y, 32'(65536));
          cfg_write(sctr_pkg::CFG_DIR_Z, 32'(65536));
          cfg_write(sctr_pkg::CFG_NEAR, 32'h80000000);
          cfg_write(sctr_pkg::CFG_FAR, 32'h7fffffff);
        end
        1: begin
          cfg_write(sctr_pkg::CFG_ORIGIN_X, 32'h7fffffff);
          cfg_write(sctr_pkg::CFG_ORIGIN_Y, 32'h80000000);
          cfg_write(sctr_pkg::CFG_ORIGIN_Z, 32'h80000000);
          cfg_write(sctr_pkg::CFG_DIR_Z, 32'(-65536));
        end
        4: begin
          // A range that nothing can satisfy.
          cfg_write(sctr_pkg::CFG_NEAR, 32'h7fffffff);
          cfg_write(sctr_pkg::CFG_FAR, 32'h80000000);
        end
        7: begin
          // Direction values outside the normalized range, one LSB of z.
          cfg_write(sctr_pkg::CFG_DIR_X, 32'(-131072));
          cfg_write(sctr_pkg::CFG_DIR_Y, 32'(131071));
          cfg_write(sctr_pkg::CFG_DIR_Z, 32'(1));
          cfg_write(sctr_pkg::CFG_NEAR, 32'(-8192));
          cfg_write(sctr_pkg::CFG_FAR, 32'(20 * sctr_pkg::ONE_Q12));
        end
        default: begin
          cfg_write(sctr_pkg::CFG_ORIGIN_X,
                    32'(longint'($urandom_range(0, 1 << 26)) - (1 << 25)));
          cfg_write(sctr_pkg::CFG_ORIGIN_Y,
                    32'(longint'($urandom_range(0, 1 << 26)) - (1 << 25)));
          cfg_write(sctr_pkg::CFG_ORIGIN_Z,
                    32'(longint'($urandom_range(0, 1 << 26)) - (1 << 25)));
          cfg_write(sctr_pkg::CFG_DIR_X, 32'(rand_dir()));
          cfg_write(sctr_pkg::CFG_DIR_Y, 32'(rand_dir()));
          cfg_write(sctr_pkg::CFG_DIR_Z, 32'(rand_dir()));
          cfg_write(sctr_pkg::CFG_NEAR,
                    32'(longint'($urandom_range(0, 8 * sctr_pkg::ONE_Q12))
                        - 4 * sctr_pkg::ONE_Q12));
          cfg_write(sctr_pkg::CFG_FAR,
                    32'(longint'($urandom_range(4, 60)) * sctr_pkg::ONE_Q12));
        end
      endcase
      cfg_we_i <= 1'b0;

      // Long output hold-off while requests keep coming, so the pipe backs up.
      if (ph == 3) hold_go = 1'b1;

      for (int n = 0; n < 88; n++) begin
        // Sender pause until the block has returned everything.
        if (ph == 6 && n == 44) drain();
        it = rand_req();
        send_req(it, 0, none);
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
